// ===== design/bsq_pkg.sv =====
// Shared types and constants for the bounded sorted priority queue.
// No dependencies; imported by bsq_cell and bounded_sorted_priority_queue.
package bsq_pkg;

    localparam int PRIO_W = 32;
    localparam int CAP_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Broadcast from the controller to every cell in the chain
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

// ===== design/bsq_cell.sv =====
// One slot of the sorted chain: holds a priority and a tag, compares against
// the incoming priority and shifts toward or away from the head. Uses bsq_pkg.
module bsq_cell
    import bsq_pkg::*;
#(
    parameter int INDEX    = 0,
    parameter int TAG_BITS = 16,
    parameter int CNT_W    = 5
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [PRIO_W-1:0] new_prio,
    input  logic [TAG_BITS-1:0]      new_tag,
    input  logic                     left_open,
    input  logic signed [PRIO_W-1:0] left_prio,
    input  logic [TAG_BITS-1:0]      left_tag,
    input  logic signed [PRIO_W-1:0] right_prio,
    input  logic [TAG_BITS-1:0]      right_tag,
    output logic                     open,
    output logic signed [PRIO_W-1:0] prio,
    output logic [TAG_BITS-1:0]      tag
);

    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic [TAG_BITS-1:0]      tag_reg;
    logic [TAG_BITS-1:0]      tag_next;
    logic                     occupied;

    assign occupied = CNT_W'(INDEX) < count;

    // Open: the new word belongs here or somewhere to the left
    assign open = !occupied || (new_prio >= prio_reg);

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (ctrl.ins_en)
        begin
            if (left_open)
            begin
                // make room: take the left neighbor's word
                prio_next = left_prio;
                tag_next  = left_tag;
            end
            else if (open)
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
        end
        else if (ctrl.rem_en)
        begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign prio = prio_reg;
    assign tag  = tag_reg;

endmodule

// ===== design/bounded_sorted_priority_queue.sv =====
// Top level of the bounded sorted priority queue: command decode, count and
// capacity registers, result register and a chain of bsq_cell. Uses bsq_pkg.
//
//  channel   signals                                   handshake
//  command   start, cmd, priority_req, task_tag        start && !busy
//  result    done, accepted, entry_count, is_empty_flag,
//            head_valid, head_tag, head_priority       done, one cycle
//  config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//
// One command per cycle: every cell compares and shifts in parallel, so the
// result appears the cycle after start and busy stays low.
// Reset clears the count to zero and capacity to 16; slot contents are not
// reset and are read only below the count.
// The result receiver cannot stall; each result is shown for one cycle.
module bounded_sorted_priority_queue
    import bsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cmd,
    input  logic signed [PRIO_W-1:0]             priority_req,
    input  logic [TAG_BITS-1:0]                  task_tag,
    output logic                                 done,
    output logic                                 accepted,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     entry_count,
    output logic                                 is_empty_flag,
    output logic                                 head_valid,
    output logic [TAG_BITS-1:0]                  head_tag,
    output logic signed [PRIO_W-1:0]             head_priority,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CAP_W-1:0]                     cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             accepted_reg;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic             cmd_take;
    logic             ins_ok;
    logic             rem_ok;
    cell_ctrl_t       ctrl;

    logic                     open_w [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] prio_w [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      tag_w  [QUEUE_DEPTH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cmd_take  = start && !busy;

    // Capacity saturates at the chain length
    assign cap_ext = CMP_W'(capacity_reg);
    assign eff_cap = (cap_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_ext;
    assign ins_ok  = CMP_W'(count_reg) < eff_cap;
    assign rem_ok  = count_reg != '0;

    assign ctrl.ins_en = cmd_take && (cmd == CMD_INSERT) && ins_ok;
    assign ctrl.rem_en = cmd_take && (cmd == CMD_REMOVE) && rem_ok;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.rem_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            count_reg    <= count_next;
            done_reg     <= cmd_take;
            accepted_reg <= ctrl.ins_en || ctrl.rem_en;
        end
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                     l_open;
            logic signed [PRIO_W-1:0] l_prio;
            logic [TAG_BITS-1:0]      l_tag;
            logic signed [PRIO_W-1:0] r_prio;
            logic [TAG_BITS-1:0]      r_tag;

            if (i == 0)
            begin : g_head
                assign l_open = 1'b0;
                assign l_prio = '0;
                assign l_tag  = '0;
            end
            else
            begin : g_mid
                assign l_open = open_w[i-1];
                assign l_prio = prio_w[i-1];
                assign l_tag  = tag_w[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                // hold: nothing to pull in past the end
                assign r_prio = prio_w[i];
                assign r_tag  = tag_w[i];
            end
            else
            begin : g_body
                assign r_prio = prio_w[i+1];
                assign r_tag  = tag_w[i+1];
            end

            bsq_cell #(
                .INDEX    (i),
                .TAG_BITS (TAG_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .new_prio   (priority_req),
                .new_tag    (task_tag),
                .left_open  (l_open),
                .left_prio  (l_prio),
                .left_tag   (l_tag),
                .right_prio (r_prio),
                .right_tag  (r_tag),
                .open       (open_w[i]),
                .prio       (prio_w[i]),
                .tag        (tag_w[i])
            );
        end
    endgenerate

    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign entry_count   = count_reg;
    assign head_valid    = count_reg != '0;
    assign is_empty_flag = !head_valid;
    assign head_tag      = head_valid ? tag_w[0] : '0;
    assign head_priority = head_valid ? prio_w[0] : '0;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for bounded_sorted_priority_queue: directed and random
// insert/remove commands and capacity writes, checked against a local queue model.
// Depends on bsq_pkg and the RTL of bounded_sorted_priority_queue.
module tb_top;
    import bsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int TAGW       = 16;
    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        logic                     accepted;
        logic [CAP_W-1:0]         count;
        logic                     empty;
        logic                     head_valid;
        logic [TAGW-1:0]          head_tag;
        logic signed [PRIO_W-1:0] head_prio;
    } queue_status_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     cmd;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TAGW-1:0]          task_tag;
    logic                     done;
    logic                     accepted;
    logic [CAP_W-1:0]         entry_count;
    logic                     is_empty_flag;
    logic                     head_valid;
    logic [TAGW-1:0]          head_tag;
    logic signed [PRIO_W-1:0] head_priority;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;

    // queue model state
    logic signed [PRIO_W-1:0] model_prio [DEPTH];
    logic [TAGW-1:0]          model_tag [DEPTH];
    int                       model_count;
    int                       model_capacity;

    queue_status_t pending_status [$];

    int errors;
    int n_items;
    int n_results;
    int n_refused;
    int n_full;
    int n_cfg;
    int idle_cycles;

    bounded_sorted_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .priority_req  (priority_req),
        .task_tag      (task_tag),
        .done          (done),
        .accepted      (accepted),
        .entry_count   (entry_count),
        .is_empty_flag (is_empty_flag),
        .head_valid    (head_valid),
        .head_tag      (head_tag),
        .head_priority (head_priority),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic queue_status_t apply_queue_cmd(logic c, logic signed [PRIO_W-1:0] p,
                                                      logic [TAGW-1:0] t);
        queue_status_t s;
        int            pos;
        int            limit;
        int            i;
        logic          ok;
        limit = (model_capacity > DEPTH) ? DEPTH : model_capacity;
        ok = 1'b0;
        if (c == CMD_INSERT)
        begin
            if (model_count < limit)
            begin
                pos = 0;
                // newest goes ahead of equal priorities
                while (pos < model_count && p < model_prio[pos])
                    pos++;
                for (i = model_count; i > pos; i--)
                begin
                    model_prio[i] = model_prio[i-1];
                    model_tag[i]  = model_tag[i-1];
                end
                model_prio[pos] = p;
                model_tag[pos]  = t;
                model_count++;
                ok = 1'b1;
            end
        end
        else if (model_count > 0)
        begin
            for (i = 0; i + 1 < model_count; i++)
            begin
                model_prio[i] = model_prio[i+1];
                model_tag[i]  = model_tag[i+1];
            end
            model_count--;
            ok = 1'b1;
        end
        s.accepted   = ok;
        s.count      = CAP_W'(model_count);
        s.empty      = (model_count == 0);
        s.head_valid = (model_count != 0);
        s.head_tag   = (model_count != 0) ? model_tag[0] : '0;
        s.head_prio  = (model_count != 0) ? model_prio[0] : '0;
        return s;
    endfunction

    // Drive one command word and hold it until the queue takes it.
    task automatic send_cmd(logic c, logic signed [PRIO_W-1:0] p, logic [TAGW-1:0] t);
        queue_status_t s;
        start        = 1'b1;
        cmd          = c;
        priority_req = p;
        task_tag     = t;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        s = apply_queue_cmd(c, p, t);
        pending_status.push_back(s);
        n_items++;
        if (!s.accepted)
            n_refused++;
        if (s.count == CAP_W'(DEPTH))
            n_full++;
        @(negedge clk);
    endtask

    task automatic sender_gap(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding result word.
    task automatic wait_drained();
        start = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        model_capacity = int'(value);
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [PRIO_W-1:0] random_priority();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: p = PRIO_W'($signed($urandom_range(0, 6)) - 3);
            4:          p = {1'b0, {(PRIO_W-1){1'b1}}};
            5:          p = {1'b1, {(PRIO_W-1){1'b0}}};
            6:          p = $urandom_range(0, 1) ? 32'sh7fff_fffe : 32'sh8000_0001;
            default:    p = $urandom;
        endcase
        return p;
    endfunction

    task automatic check_field(string label, logic [PRIO_W-1:0] want, logic [PRIO_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        queue_status_t s;
        if (rst_n && done)
        begin
            if (pending_status.size() == 0)
            begin
                errors++;
                $display("%0t ns: result word with no command outstanding", $time);
            end
            else
            begin
                s = pending_status.pop_front();
                n_results++;
                check_field("accepted", PRIO_W'(s.accepted), PRIO_W'(accepted));
                check_field("entry_count", PRIO_W'(s.count), PRIO_W'(entry_count));
                check_field("is_empty_flag", PRIO_W'(s.empty), PRIO_W'(is_empty_flag));
                check_field("head_valid", PRIO_W'(s.head_valid), PRIO_W'(head_valid));
                check_field("head_tag", PRIO_W'(s.head_tag), PRIO_W'(head_tag));
                check_field("head_priority", s.head_prio, head_priority);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no activity for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_empty_remove();
        send_cmd(CMD_REMOVE, 32'sd0, 16'h0000);
    endtask

    task automatic test_order_and_ties();
        send_cmd(CMD_INSERT, {1'b1, {(PRIO_W-1){1'b0}}}, 16'h0000);
        send_cmd(CMD_INSERT, 32'sd0, 16'h0001);
        send_cmd(CMD_INSERT, 32'sd0, 16'h0002);
        send_cmd(CMD_INSERT, {1'b0, {(PRIO_W-1){1'b1}}}, 16'hffff);
        send_cmd(CMD_REMOVE, 32'sd0, 16'h0000);
        send_cmd(CMD_INSERT, -32'sd1, 16'h5a5a);
    endtask

    // Count is 4 here; lower capacity under it, then saturate above depth.
    task automatic test_capacity_limits();
        write_capacity(CAP_W'(0));
        send_cmd(CMD_INSERT, 32'sd7, 16'h1234);
        write_capacity(CAP_W'(2));
        send_cmd(CMD_INSERT, 32'sd7, 16'h1235);
        send_cmd(CMD_REMOVE, 32'sd0, 16'h0000);
        send_cmd(CMD_INSERT, 32'sd7, 16'h1236);
        write_capacity(CAP_W'(31));
        while (model_count < DEPTH)
            send_cmd(CMD_INSERT, random_priority(), 16'($urandom));
        send_cmd(CMD_INSERT, 32'sd9, 16'habcd);
    endtask

    task automatic test_random_phase(int idle_pct, int segments, int per_seg);
        int   seg;
        int   k;
        int   insert_pct;
        logic c;
        for (seg = 0; seg < segments; seg++)
        begin
            case ($urandom_range(0, 7))
                0:       write_capacity(CAP_W'(0));
                1:       write_capacity(CAP_W'($urandom_range(1, 3)));
                2:       write_capacity(CAP_W'(16));
                3:       write_capacity(CAP_W'(31));
                4:       write_capacity(CAP_W'($urandom_range(0, 31)));
                default: write_capacity(CAP_W'($urandom_range(8, 17)));
            endcase
            case ($urandom_range(0, 3))
                0:       insert_pct = 30;
                1:       insert_pct = 50;
                2:       insert_pct = 70;
                default: insert_pct = 90;
            endcase
            for (k = 0; k < per_seg; k++)
            begin
                // idle each cycle with the given odds
                while ($urandom_range(1, 100) <= idle_pct)
                    sender_gap(1);
                c = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_REMOVE;
                send_cmd(c, random_priority(), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = CMD_INSERT;
        priority_req   = '0;
        task_tag       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        errors         = 0;
        n_items        = 0;
        n_results      = 0;
        n_refused      = 0;
        n_full         = 0;
        n_cfg          = 0;
        idle_cycles    = 0;
        model_count    = 0;
        model_capacity = int'(CAP_RESET);
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_remove();
        test_order_and_ties();
        test_capacity_limits();
        test_random_phase(15, 9, 50);
        test_random_phase(55, 9, 50);
        test_random_phase(0, 9, 50);

        wait_drained();
        repeat (3) @(posedge clk);
        $display("Covered %0d commands (%0d refused, %0d reaching a full queue), %0d results",
                 n_items, n_refused, n_full, n_results);
        $display("and %0d capacity writes, with sender idle rates of 15, 55 and 0 percent.",
                 n_cfg);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bsq_pkg.sv
design/bsq_cell.sv
design/bounded_sorted_priority_queue.sv
test/tb_top.sv
